// ===== rtl/hrcr_pkg.sv =====
package hrcr_pkg;

  // default frame limits
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // field and register widths
  localparam int PIX_W      = 16;
  localparam int CFG_SIZE_W = 9;
  localparam int TH_W       = 48;
  localparam int CNT_W      = 15;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;
  localparam int CH_W       = 8;

  // register map, one 64-bit register every 8 bytes
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOP_TH       = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM_TH    = 2'd3;

  // register reset values
  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_WIDTH  = 9'd240;
  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_HEIGHT = 9'd240;
  localparam logic [TH_W-1:0]       RST_TOP_TH       = 48'hFF55_FF50_2D0A;
  localparam logic [TH_W-1:0]       RST_BOTTOM_TH    = 48'hFF78_FF64_2305;

  // hue scale: 43 steps per sextant
  localparam logic [CH_W-1:0] HUE_STEP   = 8'd43;
  localparam logic [CH_W-1:0] HUE_R_BASE = 8'd0;
  localparam logic [CH_W-1:0] HUE_G_BASE = 8'd85;
  localparam logic [CH_W-1:0] HUE_B_BASE = 8'd171;
  localparam logic [CH_W:0]   HUE_WRAP   = 9'd180;

  localparam logic [CNT_W-1:0] COUNT_MAX = 15'h7FFF;

  // shared divider: 16-bit dividend, 8-bit divisor, 8-bit quotient
  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_Q_W   = 8;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/hsv_region_color_ratio_detector.sv =====
// Color ratio detector over an RGB565 frame.
// Pixels arrive in raster order on the in_ channel (valid/ready), one beat per
// pixel. Even columns of even rows in the top half, and of rows at an even
// offset from height/2 in the bottom half, are converted to 8-bit HSV and
// checked against the top or bottom threshold set; hits are counted per half.
// On the last pixel of a frame one result beat leaves on the out_ channel with
// both hit counts and the helmet and vest flags; the counts then start over.
// A skipped pixel goes straight to the bookkeeping state. A sampled pixel runs
// the channel compare, then a hue pass and a saturation pass through the one
// bit-serial divider, each after its divider load, then the threshold check
// and bookkeeping; a pixel with max equal to min skips both divider passes.
// A new pixel is taken only once the last one is through; the result beat is
// loaded in the bookkeeping state of the last pixel of a frame.
// The result sits in an output register; while the receiver stalls, further
// pixels are still taken, and only a frame end waits for the register to free.
// Frame size and thresholds are written over the APB port and apply at once.
// Synchronous reset clears position, counts and the output valid, and loads
// the default registers (240x240 frame and the default thresholds).
module hsv_region_color_ratio_detector
  import hrcr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel beats
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  // result beats
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_helmet_present,
  output logic                  out_vest_present,
  output logic [CNT_W-1:0]      out_top_hits,
  output logic [CNT_W-1:0]      out_bottom_hits,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int XW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WWR = $clog2(MAX_WIDTH + 1);
  localparam int HWR = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = (WWR > CFG_SIZE_W) ? WWR : CFG_SIZE_W;
  localparam int CH  = (HWR > CFG_SIZE_W) ? HWR : CFG_SIZE_W;
  localparam int PW  = (CW + CH > CNT_W + 5) ? CW + CH : CNT_W + 5;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_HGO   = 3'd2;
  localparam logic [2:0] ST_HWAIT = 3'd3;
  localparam logic [2:0] ST_SGO   = 3'd4;
  localparam logic [2:0] ST_SWAIT = 3'd5;
  localparam logic [2:0] ST_CMP   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  // registers
  logic [CFG_SIZE_W-1:0] frame_width_r;
  logic [CFG_SIZE_W-1:0] frame_height_r;
  logic [TH_W-1:0]       top_th_r;
  logic [TH_W-1:0]       bot_th_r;

  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1 -: REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      top_th_r       <= RST_TOP_TH;
      bot_th_r       <= RST_BOTTOM_TH;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[CFG_SIZE_W-1:0];
        REG_TOP_TH:       top_th_r       <= pwdata[TH_W-1:0];
        REG_BOTTOM_TH:    bot_th_r       <= pwdata[TH_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_r);
      REG_TOP_TH:       prdata = CFG_DATA_W'(top_th_r);
      REG_BOTTOM_TH:    prdata = CFG_DATA_W'(bot_th_r);
      default:          prdata = '0;
    endcase
  end

  // effective frame size, clamped into [1, max]
  logic [CW-1:0] fw_ext;
  logic [CH-1:0] fh_ext;
  logic [CW-1:0] eff_w;
  logic [CH-1:0] eff_h;
  logic [CH-1:0] half_h;

  assign fw_ext = CW'(frame_width_r);
  assign fh_ext = CH'(frame_height_r);
  assign eff_w  = (fw_ext == '0) ? CW'(1) :
                  (fw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_ext;
  assign eff_h  = (fh_ext == '0) ? CH'(1) :
                  (fh_ext > CH'(MAX_HEIGHT)) ? CH'(MAX_HEIGHT) : fh_ext;
  assign half_h = eff_h >> 1;

  // half-frame pixel total, registered after the multiply
  logic [PW-1:0] total_r;

  always_ff @(posedge clk) begin
    total_r <= PW'((eff_w * eff_h) >> 1);
  end

  // sequencer
  logic [2:0]     state_r;
  logic [2:0]     state_nxt;
  logic           in_beat;
  logic           out_free;

  logic [XW-1:0]  x_r;
  logic [YW-1:0]  y_r;
  logic [CW-1:0]  x_inc;
  logic [CH-1:0]  y_inc;
  logic           row_end;
  logic           frame_end;
  logic           col_ok;
  logic           in_top;
  logic           smp_top;
  logic           smp_bot;

  logic [PIX_W-1:0] pix_r;
  logic             smp_top_r;
  logic             frame_end_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic           d_zero;

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // position decode on the pixel being taken
  assign x_inc     = CW'(x_r) + CW'(1);
  assign y_inc     = CH'(y_r) + CH'(1);
  assign row_end   = x_inc >= eff_w;
  assign frame_end = row_end && (y_inc >= eff_h);
  assign col_ok    = !x_r[0] && (CW'(x_r) < eff_w) && (CH'(y_r) < eff_h);
  assign in_top    = CH'(y_r) < half_h;
  assign smp_top   = col_ok && in_top && !y_r[0];
  assign smp_bot   = col_ok && !in_top && (y_r[0] == half_h[0]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = (smp_top || smp_bot) ? ST_PREP : ST_FIN;
      ST_PREP:  state_nxt = d_zero ? ST_CMP : ST_HGO;
      ST_HGO:   state_nxt = ST_HWAIT;
      ST_HWAIT: if (div_rsp.done) state_nxt = ST_SGO;
      ST_SGO:   state_nxt = ST_SWAIT;
      ST_SWAIT: if (div_rsp.done) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_FIN;
      ST_FIN:   if (!frame_end_r || out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      x_r     <= '0;
      y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_beat) begin
        x_r <= row_end ? '0 : XW'(x_inc);
        if (row_end) y_r <= frame_end ? '0 : YW'(y_inc);
      end
    end
  end

  // per-pixel payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      pix_r       <= in_pixel;
      smp_top_r   <= smp_top;
      frame_end_r <= frame_end;
    end
  end

  // channel widening and max/min
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] grn;
  logic [CH_W-1:0] blu;
  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;
  logic [CH_W-1:0] dif_a;
  logic [CH_W-1:0] dif_b;
  logic [CH_W-1:0] base;
  logic            dif_neg;
  logic [CH_W-1:0] dif_abs;

  assign red = {pix_r[15:11], 3'b000};
  assign grn = {pix_r[10:5], 2'b00};
  assign blu = {pix_r[4:0], 3'b000};

  always_comb begin
    mx = (red > grn) ? ((red > blu) ? red : blu) : ((grn > blu) ? grn : blu);
    mn = (red < grn) ? ((red < blu) ? red : blu) : ((grn < blu) ? grn : blu);
    if (mx == red) begin
      dif_a = grn;
      dif_b = blu;
      base  = HUE_R_BASE;
    end else if (mx == grn) begin
      dif_a = blu;
      dif_b = red;
      base  = HUE_G_BASE;
    end else begin
      dif_a = red;
      dif_b = grn;
      base  = HUE_B_BASE;
    end
    dif_neg = dif_a < dif_b;
    dif_abs = dif_neg ? (dif_b - dif_a) : (dif_a - dif_b);
  end

  assign d_zero = (mx == mn);

  // hsv working registers
  logic [CH_W-1:0]      mx_r;
  logic [CH_W-1:0]      d_r;
  logic [CH_W-1:0]      base_r;
  logic                 neg_r;
  logic [DIV_NUM_W-1:0] hnum_r;
  logic [CH_W-1:0]      hue_r;
  logic [CH_W-1:0]      sat_r;
  logic [CH_W:0]        hue_sum;

  // signed hue offset; a result below zero is folded back by adding 180
  always_comb begin
    if (!neg_r) begin
      hue_sum = {1'b0, base_r} + {1'b0, div_rsp.quo};
    end else if (base_r < div_rsp.quo) begin
      hue_sum = HUE_WRAP + {1'b0, base_r} - {1'b0, div_rsp.quo};
    end else begin
      hue_sum = {1'b0, base_r} - {1'b0, div_rsp.quo};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      mx_r   <= mx;
      d_r    <= mx - mn;
      base_r <= base;
      neg_r  <= dif_neg;
      hnum_r <= DIV_NUM_W'(dif_abs) * DIV_NUM_W'(HUE_STEP);
      if (d_zero) begin
        hue_r <= '0;
        sat_r <= '0;
      end
    end
    if (state_r == ST_HWAIT && div_rsp.done) hue_r <= hue_sum[CH_W-1:0];
    if (state_r == ST_SWAIT && div_rsp.done) sat_r <= div_rsp.quo;
  end

  // shared divider: hue offset first, then saturation as d*255/max
  assign div_req.start = (state_r == ST_HGO) || (state_r == ST_SGO);
  assign div_req.num   = (state_r == ST_SGO) ?
                         (DIV_NUM_W'({d_r, 8'h00}) - DIV_NUM_W'(d_r)) : hnum_r;
  assign div_req.den   = (state_r == ST_SGO) ? mx_r : d_r;

  hrcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // threshold window check
  logic [TH_W-1:0] th;
  logic            hit;

  assign th  = smp_top_r ? top_th_r : bot_th_r;
  assign hit = (hue_r >= th[7:0])   && (hue_r <= th[15:8]) &&
               (sat_r >= th[23:16]) && (sat_r <= th[31:24]) &&
               (mx_r  >= th[39:32]) && (mx_r  <= th[47:40]);

  // hit counters and result register
  logic [CNT_W-1:0] top_cnt_r;
  logic [CNT_W-1:0] bot_cnt_r;
  logic             out_valid_r;
  logic             helmet_r;
  logic             vest_r;
  logic [CNT_W-1:0] top_out_r;
  logic [CNT_W-1:0] bot_out_r;
  logic             load_out;
  logic [PW-1:0]    tc_ext;
  logic [PW-1:0]    bc_ext;
  logic             helmet;
  logic             vest;

  assign load_out = (state_r == ST_FIN) && frame_end_r && out_free;
  assign tc_ext   = PW'(top_cnt_r);
  assign bc_ext   = PW'(bot_cnt_r);
  assign helmet   = (total_r != '0) &&
                    (((tc_ext << 4) + (tc_ext << 2)) > total_r) &&
                    (((tc_ext << 2) + tc_ext) < total_r);
  assign vest     = (total_r != '0) && ((bc_ext << 2) > total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_cnt_r   <= '0;
      bot_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CMP && hit) begin
        if (smp_top_r && top_cnt_r != COUNT_MAX) top_cnt_r <= top_cnt_r + 1'b1;
        if (!smp_top_r && bot_cnt_r != COUNT_MAX) bot_cnt_r <= bot_cnt_r + 1'b1;
      end
      if (load_out) begin
        top_cnt_r   <= '0;
        bot_cnt_r   <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      helmet_r  <= helmet;
      vest_r    <= vest;
      top_out_r <= top_cnt_r;
      bot_out_r <= bot_cnt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_helmet_present = helmet_r;
  assign out_vest_present   = vest_r;
  assign out_top_hits       = top_out_r;
  assign out_bottom_hits    = bot_out_r;

endmodule

// ===== rtl/hrcr_div.sv =====
module hrcr_div
  import hrcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DIV_Q_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_Q_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_W-1:0]    step_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_Q_W-1:0]   quo_r;

  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[DIV_NUM_W-1 -: DIV_DEN_W];
      quo_r <= req.num[DIV_Q_W-1:0];
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_Q_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== rtl/hrcr_check.sv =====
module hrcr_check
  import hrcr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [PIX_W-1:0]      in_pixel,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_helmet_present,
  input logic                  out_vest_present,
  input logic [CNT_W-1:0]      out_top_hits,
  input logic [CNT_W-1:0]      out_bottom_hits,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [CFG_DATA_W-1:0] pwdata,
  input logic [CFG_DATA_W-1:0] prdata,
  input logic                  pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable(out_top_hits) && $stable(out_bottom_hits) &&
      $stable(out_helmet_present) && $stable(out_vest_present))
    else $error("result beat changed while stalled");

  // one pixel at a time: busy right after a pixel beat
  a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel taken while previous pixel in flight");

  // helmet flag needs top hits
  a_helmet_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_helmet_present |-> out_top_hits != '0)
    else $error("helmet flag with no top hits");

  // vest flag needs bottom hits
  a_vest_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vest_present |-> out_bottom_hits != '0)
    else $error("vest flag with no bottom hits");

endmodule

bind hsv_region_color_ratio_detector hrcr_check u_hrcr_check (.*);

// ===== dv/hsv_region_color_ratio_detector_test.sv =====
module hsv_region_color_ratio_detector_test;
  import hrcr_pkg::*;

  localparam int MAX_W       = DEF_MAX_WIDTH;
  localparam int MAX_H       = DEF_MAX_HEIGHT;
  localparam int LATENCY_PAD = 40;
  localparam int LONG_HOLD   = 400;
  localparam int LIMIT_TIME  = 3000000;
  localparam logic [TH_W-1:0] ALL_PASS = 48'hFF00_FF00_FF00;

  // hand-picked pixels for a 5x4 frame; sampled spots are rows 0 and 2, even columns
  localparam logic [PIX_W-1:0] CORNER_PIXELS [20] = '{
    16'h0000, 16'hFFFF, 16'hFC00, 16'h1234, 16'hF81F,
    16'hF800, 16'h07E0, 16'h001F, 16'hFFE0, 16'h07FF,
    16'hF800, 16'h8410, 16'hFB00, 16'h5555, 16'h001F,
    16'hAAAA, 16'hFFFF, 16'h0001, 16'h8000, 16'h0020
  };

  typedef struct packed {
    logic             helmet;
    logic             vest;
    logic [CNT_W-1:0] top_hits;
    logic [CNT_W-1:0] bottom_hits;
  } frame_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_helmet_present;
  logic                  out_vest_present;
  logic [CNT_W-1:0]      out_top_hits;
  logic [CNT_W-1:0]      out_bottom_hits;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // register copies seen by the predictor and the pixel generator
  logic [CFG_SIZE_W-1:0] cfg_width  = RST_FRAME_WIDTH;
  logic [CFG_SIZE_W-1:0] cfg_height = RST_FRAME_HEIGHT;
  logic [TH_W-1:0]       cfg_top_th = RST_TOP_TH;
  logic [TH_W-1:0]       cfg_bot_th = RST_BOTTOM_TH;

  // predictor state
  int pred_col = 0;
  int pred_row = 0;
  int top_cnt  = 0;
  int bot_cnt  = 0;

  // generator position, tracks where each queued pixel will land
  int gen_col = 0;
  int gen_row = 0;

  logic [PIX_W-1:0] pixel_q [$];
  frame_report_t    frame_reports_q [$];

  int gen_pixels      = 0;
  int gen_frames      = 0;
  int pixels_taken    = 0;
  int reports_checked = 0;
  int cfg_writes      = 0;
  int errors          = 0;
  bit no_gaps         = 1'b0;
  bit hold_armed      = 1'b0;
  bit hold_done       = 1'b0;
  int hold_left       = 0;

  hsv_region_color_ratio_detector u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pixel           (in_pixel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_helmet_present (out_helmet_present),
    .out_vest_present   (out_vest_present),
    .out_top_hits       (out_top_hits),
    .out_bottom_hits    (out_bottom_hits),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #2 clk = ~clk;

  // saturate a size register into [1, hi]
  function automatic int eff_size(logic [CFG_SIZE_W-1:0] v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // rgb565 -> 8-bit hsv, then window test against one threshold set
  function automatic bit hsv_inside(logic [PIX_W-1:0] px, logic [TH_W-1:0] th);
    int r, g, b, mx, mn, d, hue, sat;
    r = int'(px[15:11]) << 3;
    g = int'(px[10:5]) << 2;
    b = int'(px[4:0]) << 3;
    mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    d = mx - mn;
    hue = 0;
    sat = 0;
    if (d != 0) begin
      if (mx == r) hue = int'(HUE_R_BASE) + int'(HUE_STEP) * (g - b) / d;
      else if (mx == g) hue = int'(HUE_G_BASE) + int'(HUE_STEP) * (b - r) / d;
      else hue = int'(HUE_B_BASE) + int'(HUE_STEP) * (r - g) / d;
      if (hue < 0) hue += int'(HUE_WRAP);
    end
    if (mx != 0) sat = d * 255 / mx;
    return hue >= int'(th[7:0])   && hue <= int'(th[15:8]) &&
           sat >= int'(th[23:16]) && sat <= int'(th[31:24]) &&
           mx  >= int'(th[39:32]) && mx  <= int'(th[47:40]);
  endfunction

  // raster advance; a column at or past w-1 ends the row, a row at or past h-1 the frame
  function automatic bit step_position(inout int c, inout int r, input int w, input int h);
    if (c + 1 >= w) begin
      c = 0;
      if (r + 1 >= h) begin
        r = 0;
        return 1'b1;
      end
      r = r + 1;
    end else begin
      c = c + 1;
    end
    return 1'b0;
  endfunction

  // hit counting per accepted pixel, frame report on the last one
  function automatic void predict_pixel(logic [PIX_W-1:0] px);
    int w, h, half, total;
    frame_report_t rep;
    w = eff_size(cfg_width, MAX_W);
    h = eff_size(cfg_height, MAX_H);
    half = h / 2;
    if (pred_col % 2 == 0 && pred_col < w && pred_row < h) begin
      if (pred_row < half) begin
        if (pred_row % 2 == 0 && hsv_inside(px, cfg_top_th) && top_cnt < int'(COUNT_MAX))
          top_cnt++;
      end else if ((pred_row - half) % 2 == 0 && hsv_inside(px, cfg_bot_th) &&
                   bot_cnt < int'(COUNT_MAX)) begin
        bot_cnt++;
      end
    end
    if (step_position(pred_col, pred_row, w, h)) begin
      total = w * h / 2;
      rep.helmet      = total != 0 && 20 * top_cnt > total && 5 * top_cnt < total;
      rep.vest        = total != 0 && 4 * bot_cnt > total;
      rep.top_hits    = CNT_W'(top_cnt);
      rep.bottom_hits = CNT_W'(bot_cnt);
      frame_reports_q.push_back(rep);
      top_cnt = 0;
      bot_cnt = 0;
    end
  endfunction

  // random pixel that lands inside (or outside) a threshold set, if one turns up
  function automatic logic [PIX_W-1:0] pick_pixel(bit want_hit, logic [TH_W-1:0] th);
    logic [PIX_W-1:0] px;
    px = '0;
    for (int k = 0; k < 16; k++) begin
      px = PIX_W'($urandom_range(16'hFFFF, 0));
      if (hsv_inside(px, th) == want_hit) return px;
    end
    return px;
  endfunction

  // queue one pixel (given, or random with a hit bias); returns 1 on a frame end
  function automatic bit push_pixel(int hit_pct, int given = -1);
    int w, h;
    logic [TH_W-1:0] th;
    w = eff_size(cfg_width, MAX_W);
    h = eff_size(cfg_height, MAX_H);
    th = (gen_row < h / 2) ? cfg_top_th : cfg_bot_th;
    if (given >= 0) pixel_q.push_back(PIX_W'(given));
    else pixel_q.push_back(pick_pixel($urandom_range(99) < hit_pct, th));
    gen_pixels++;
    return step_position(gen_col, gen_row, w, h);
  endfunction

  task automatic push_frames(int n, int hit_pct);
    int done;
    done = 0;
    while (done < n) begin
      if (push_pixel(hit_pct)) done++;
    end
    gen_frames += n;
  endtask

  function automatic logic [TH_W-1:0] random_thresholds(logic [TH_W-1:0] dflt);
    logic [TH_W-1:0] th;
    int lo;
    th = '0;
    case ($urandom_range(6))
      0: return ALL_PASS;
      1: return dflt;
      2: return TH_W'({$urandom(), $urandom()});
      3: return $urandom_range(1) ? {TH_W{1'b0}} : {TH_W{1'b1}};
      default: begin
        // ordered window per channel
        for (int c = 0; c < 3; c++) begin
          lo = $urandom_range(255);
          th[16*c +: 8]     = 8'(lo);
          th[16*c + 8 +: 8] = 8'(lo + $urandom_range(255 - lo));
        end
        return th;
      end
    endcase
  endfunction

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cfg_width  = val[CFG_SIZE_W-1:0];
      REG_FRAME_HEIGHT: cfg_height = val[CFG_SIZE_W-1:0];
      REG_TOP_TH:       cfg_top_th = val[TH_W-1:0];
      REG_BOTTOM_TH:    cfg_bot_th = val[TH_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // every pixel taken and every report back, then let a sampled pixel finish
  task automatic wait_idle();
    do @(posedge clk); while (pixels_taken != gen_pixels || frame_reports_q.size() != 0);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic compare_field(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // pixel driver: holds a beat until taken, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_pixel(in_pixel);
        pixels_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pixel_q.size() != 0 && (no_gaps || $urandom_range(99) >= 36)) begin
          in_valid <= 1'b1;
          in_pixel <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : result_monitor
    frame_report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_reports_q.size() == 0) begin
          $display("%0t: frame report with none expected: helmet %0b vest %0b top %0d bottom %0d",
                   $time, out_helmet_present, out_vest_present, out_top_hits, out_bottom_hits);
          errors++;
        end else begin
          want = frame_reports_q.pop_front();
          compare_field("helmet_present", CNT_W'(want.helmet), CNT_W'(out_helmet_present));
          compare_field("vest_present", CNT_W'(want.vest), CNT_W'(out_vest_present));
          compare_field("top_hits", want.top_hits, out_top_hits);
          compare_field("bottom_hits", want.bottom_hits, out_bottom_hits);
          reports_checked++;
        end
      end
      if (hold_armed && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= 36);
      end
    end
  end

  initial begin : stimulus
    int n, k, w, h, px_mark, fr_mark;
    bit frame_end;
    logic [CFG_SIZE_W-1:0] wv, hv;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner pixels against the reset thresholds in a 5x4 frame
    write_reg(REG_FRAME_WIDTH, 5);
    write_reg(REG_FRAME_HEIGHT, 4);
    for (int i = 0; i < 20; i++) frame_end = push_pixel(0, int'(CORNER_PIXELS[i]));
    gen_frames++;

    // 1x1 frames: zero total, every row in the bottom half
    wait_idle();
    write_reg(REG_TOP_TH, ALL_PASS);
    write_reg(REG_BOTTOM_TH, '0);
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 1);
    frame_end = push_pixel(0, 16'h0000);
    frame_end = push_pixel(0, 16'hFFFF);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 0);
    frame_end = push_pixel(0, 16'h0000);
    gen_frames += 3;

    // oversized width and height saturate to the maximum
    wait_idle();
    write_reg(REG_BOTTOM_TH, ALL_PASS);
    write_reg(REG_FRAME_WIDTH, 511);
    write_reg(REG_FRAME_HEIGHT, 2);
    push_frames(1, 50);
    wait_idle();
    write_reg(REG_TOP_TH, random_thresholds(RST_TOP_TH));
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 300);
    push_frames(1, 30);

    // frame size shrinks mid-frame: row ends past the new width, frame past the new height
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 6);
    write_reg(REG_FRAME_HEIGHT, 6);
    for (int i = 0; i < 15; i++) frame_end = push_pixel(60);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 3);
    for (int i = 0; i < 4; i++) frame_end = push_pixel(60);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 2);
    push_frames(1, 60);

    // long receiver stall over tiny frames so the input backs up
    wait_idle();
    write_reg(REG_TOP_TH, ALL_PASS);
    write_reg(REG_BOTTOM_TH, ALL_PASS);
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    hold_armed <= 1'b1;
    push_frames(12, 50);

    // stretch with no gaps on either side
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 4);
    write_reg(REG_TOP_TH, RST_TOP_TH);
    write_reg(REG_BOTTOM_TH, RST_BOTTOM_TH);
    no_gaps <= 1'b1;
    push_frames(8, 40);
    wait_idle();
    no_gaps <= 1'b0;

    // random frames, random sizes and thresholds, now and then a cut-off frame
    px_mark = gen_pixels;
    fr_mark = gen_frames;
    while (gen_pixels - px_mark < 450 || gen_frames - fr_mark < 40) begin
      if ($urandom_range(2) == 0 || gen_frames == fr_mark) begin
        wait_idle();
        case ($urandom_range(9))
          0: begin
            wv = CFG_SIZE_W'($urandom_range(511));
            hv = CFG_SIZE_W'($urandom_range(3));
          end
          1: begin
            wv = CFG_SIZE_W'($urandom_range(3));
            hv = CFG_SIZE_W'($urandom_range(511));
          end
          default: begin
            wv = CFG_SIZE_W'($urandom_range(2, 8));
            hv = CFG_SIZE_W'($urandom_range(2, 8));
          end
        endcase
        write_reg(REG_FRAME_WIDTH, wv);
        write_reg(REG_FRAME_HEIGHT, hv);
        write_reg(REG_TOP_TH, random_thresholds(RST_TOP_TH));
        write_reg(REG_BOTTOM_TH, random_thresholds(RST_BOTTOM_TH));
      end
      w = eff_size(cfg_width, MAX_W);
      h = eff_size(cfg_height, MAX_H);
      n = (w * h > 64) ? 1 : $urandom_range(1, 3);
      push_frames(n, $urandom_range(100));
      if ($urandom_range(7) == 0) begin
        k = $urandom_range(1, 10);
        for (int i = 0; i < k; i++) begin
          if (push_pixel($urandom_range(100))) gen_frames++;
        end
      end
    end

    // drain: all pixels taken, all reports back, with a bound
    k = 0;
    while ((pixels_taken != gen_pixels || frame_reports_q.size() != 0) && k < 50000) begin
      @(posedge clk);
      k++;
    end
    repeat (LATENCY_PAD) @(posedge clk);
    if (frame_reports_q.size() != 0) begin
      $display("%0t: %0d frame reports never arrived", $time, frame_reports_q.size());
      errors++;
    end
    $display("%0d pixels in %0d frames, %0d frame reports checked, %0d register writes",
             pixels_taken, gen_frames, reports_checked, cfg_writes);
    $display("frames from 1x1 to saturated 256-wide and 256-tall, thresholds from empty to open");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #LIMIT_TIME;
    $display("%0t: timeout, %0d reports still expected", $time, frame_reports_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hrcr_pkg.sv
rtl/hrcr_div.sv
rtl/hsv_region_color_ratio_detector.sv
rtl/hrcr_check.sv
dv/hsv_region_color_ratio_detector_test.sv
